// ----- rtl/sorted_timer_event_queue_macros.svh -----
// ----------------------------------------------------------------------------
// sorted timer event queue assertion macros
// concurrent checks clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EVENT_QUEUE_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STQ_ASSERT_IMP(label, ante, cons, msg)
`define STQ_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg
// shared types and constants of the sorted timer event queue
// ----------------------------------------------------------------------------
package stq_pkg;

    // number of cells in the queue
    localparam int QUEUE_DEPTH = 16;
    // bound on events fired by one tick
    localparam int MAX_FIRES   = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_FIRES + 1);

    // result kinds
    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_FIRED    = 2'd2
    } t_kind;

    // input operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // one queue entry
    typedef struct packed {
        logic        valid;
        logic [63:0] deadline;
        logic [7:0]  ident;
        logic [31:0] period;
        logic        repeats;
    } t_entry;

    // chain commands
    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_ctl;

    // chain status seen by the controller
    typedef struct packed {
        t_entry                   head;
        logic [QUEUE_DEPTH-1:0]   valid_vec;
    } t_chain_sts;

endpackage

// ----- rtl/stq_cell.sv -----
// ----------------------------------------------------------------------------
// stq_cell
// one slot of the sorted queue: holds, shifts down on insert, shifts up on pop
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stq_pkg::t_chain_ctl i_ctl,
    input  stq_pkg::t_entry     i_new,
    input  stq_pkg::t_entry     i_prev,
    input  logic                i_prev_keep,
    input  stq_pkg::t_entry     i_next,
    output stq_pkg::t_entry     o_entry,
    output logic                o_keep
);
    import stq_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;

    // visible entry with the reset-cleared valid bit
    always_comb begin
        o_entry       = r_entry;
        o_entry.valid = r_valid;
    end

    // entry stays put when it sorts at or before the new one
    assign o_keep = r_valid && (r_entry.deadline <= i_new.deadline);

    // next content of the slot
    always_comb begin
        n_entry = o_entry;
        if (i_ctl.insert) begin
            if (!o_keep) begin
                n_entry = i_prev_keep ? i_new : i_prev;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/stq_chain.sv -----
// ----------------------------------------------------------------------------
// stq_chain
// row of queue cells, head at cell zero
// ----------------------------------------------------------------------------
module stq_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stq_pkg::t_chain_ctl i_ctl,
    input  stq_pkg::t_entry     i_new,
    output stq_pkg::t_chain_sts o_sts
);
    import stq_pkg::*;

    t_entry w_entry [QUEUE_DEPTH];
    logic   w_keep  [QUEUE_DEPTH];
    t_entry w_prev  [QUEUE_DEPTH];
    logic   w_pkeep [QUEUE_DEPTH];
    t_entry w_next  [QUEUE_DEPTH];

    // neighbor wiring: the head sees a kept predecessor, the tail an empty successor
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i == 0) begin
                w_prev[i]  = i_new;
                w_pkeep[i] = 1'b1;
            end else begin
                w_prev[i]  = w_entry[i-1];
                w_pkeep[i] = w_keep[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin
                w_next[i] = '0;
            end else begin
                w_next[i] = w_entry[i+1];
            end
        end
    end

    // cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        stq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_new       (i_new),
            .i_prev      (w_prev[g]),
            .i_prev_keep (w_pkeep[g]),
            .i_next      (w_next[g]),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    // status
    always_comb begin
        o_sts.head = w_entry[0];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            o_sts.valid_vec[i] = w_entry[i].valid;
        end
    end

endmodule

// ----- rtl/sorted_timer_event_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// 64-bit tick counter with a deadline-sorted queue of timer events
// ----------------------------------------------------------------------------
// Events sit in a row of cells kept in deadline order, ties in arrival order;
// every insert or pop moves the whole row at once. An add is accepted, then
// inserted if there is room in S_ADD, which gives one result with last set.
// A tick is accepted, then the head is checked in S_CHECK and each due event
// is popped and fired, at most MAX_FIRES per tick; a periodic event is
// reinserted in S_REARM before the head is checked again. A result
// waiting in the output register stalls the controller until it is taken.
// No clearing pass after reset: the cell valid bits reset at once.
`include "sorted_timer_event_queue_macros.svh"

module sorted_timer_event_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [31:0] i_duration,
    input  logic [7:0]  i_event_id,
    input  logic        i_periodic,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_fired_id,
    output logic [63:0] o_fire_time,
    output logic        o_last
);
    import stq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_CHECK,
        S_REARM
    } t_state;

    t_state                r_state;
    logic [63:0]           r_now;
    t_entry                r_ins;
    logic [FIRE_CNT_W-1:0] r_fire_cnt;
    logic                  r_pend_v;
    logic [7:0]            r_pend_id;
    logic                  r_out_valid;
    logic [1:0]            r_out_kind;
    logic [7:0]            r_out_id;
    logic [63:0]           r_out_time;
    logic                  r_out_last;

    t_chain_ctl w_ctl;
    t_chain_sts w_sts;
    logic       w_full;
    logic       w_due;
    logic       w_out_free;
    logic       w_out_load;
    logic       w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_full      = w_sts.valid_vec[QUEUE_DEPTH-1];
    assign w_due       = w_sts.head.valid && (w_sts.head.deadline <= r_now) &&
                         (r_fire_cnt < FIRE_CNT_W'(MAX_FIRES));
    // a new result enters the output register this cycle
    assign w_out_load  = w_out_free &&
                         ((r_state == S_ADD) || ((r_state == S_CHECK) && r_pend_v));

    // chain commands
    always_comb begin
        w_ctl.insert = ((r_state == S_ADD) && w_out_free && !w_full) ||
                       (r_state == S_REARM);
        w_ctl.pop    = (r_state == S_CHECK) && w_due && (!r_pend_v || w_out_free);
    end

    stq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_new   (r_ins),
        .o_sts   (w_sts)
    );

    // controller and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_fire_cnt  <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_operation == OP_ADD) begin
                            r_ins.valid    <= 1'b1;
                            r_ins.deadline <= r_now + {32'd0, i_duration};
                            r_ins.ident    <= i_event_id;
                            r_ins.period   <= i_duration;
                            r_ins.repeats  <= i_periodic;
                            r_state        <= S_ADD;
                        end else begin
                            r_now      <= r_now + 64'd1;
                            r_fire_cnt <= '0;
                            r_pend_v   <= 1'b0;
                            r_state    <= S_CHECK;
                        end
                    end
                end
                S_ADD: begin
                    if (w_out_free) begin
                        r_out_kind  <= w_full ? KIND_ADD_FULL : KIND_ADD_OK;
                        r_out_id    <= r_ins.ident;
                        r_out_time  <= r_now;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    if (w_due) begin
                        if (!r_pend_v || w_out_free) begin
                            // earlier firing was not the last one
                            if (r_pend_v) begin
                                r_out_kind  <= KIND_FIRED;
                                r_out_id    <= r_pend_id;
                                r_out_time  <= r_now;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_v       <= 1'b1;
                            r_pend_id      <= w_sts.head.ident;
                            r_fire_cnt     <= r_fire_cnt + FIRE_CNT_W'(1);
                            r_ins.valid    <= 1'b1;
                            r_ins.deadline <= r_now + {32'd0, w_sts.head.period};
                            r_ins.ident    <= w_sts.head.ident;
                            r_ins.period   <= w_sts.head.period;
                            r_ins.repeats  <= 1'b1;
                            r_state        <= w_sts.head.repeats ? S_REARM : S_CHECK;
                        end
                    end else if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        // final firing of this tick
                        r_out_kind  <= KIND_FIRED;
                        r_out_id    <= r_pend_id;
                        r_out_time  <= r_now;
                        r_out_last  <= 1'b1;
                        r_pend_v    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_REARM: begin
                    r_state <= S_CHECK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_fired_id  = r_out_id;
    assign o_fire_time = r_out_time;
    assign o_last      = r_out_last;

    // valid entries always form a prefix of the row
    `STQ_ASSERT_IMP(a_valid_prefix, 1'b1,
        (w_sts.valid_vec & (w_sts.valid_vec + QUEUE_DEPTH'(1))) == '0,
        "queue valid bits not a prefix")
    // a reinsert follows a pop, so a slot is always free
    `STQ_ASSERT_IMP(a_rearm_room, r_state == S_REARM, !w_full, "reinsert into full queue")
    // fire count stays within the per-tick bound
    `STQ_ASSERT_IMP(a_fire_bound, 1'b1, r_fire_cnt <= FIRE_CNT_W'(MAX_FIRES),
        "fire count over bound")
    // an accepted tick advances the time counter by one
    `STQ_ASSERT_NXT(a_tick_step, w_accept && (i_operation == OP_TICK),
        r_now == $past(r_now) + 64'd1, "tick did not advance time")

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted timer event queue: a clocked driver
// feeds add and tick requests from a backlog with random gaps, a clocked
// monitor takes results with random stalls and checks every field against a
// deadline-ordered model of the queue and its time counter
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    // one request as presented on the input channel
    typedef struct packed {
        logic        op;
        logic [31:0] dur;
        logic [7:0]  ident;
        logic        rearm;
    } t_req;

    // one expected result
    typedef struct {
        t_kind       kind;
        logic [7:0]  ident;
        logic [63:0] stamp;
        logic        last;
    } t_fire_rec;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_req        drv_req   = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_fired_id;
    logic [63:0] o_fire_time;
    logic        o_last;

    // request backlog and expected results
    t_req        req_backlog[$];
    t_fire_rec   awaited_results[$];
    bit          stim_ready = 1'b0;

    // model of the queue: valid entries are always slots 0..queued-1
    logic [63:0] now_ticks;
    logic [63:0] slot_deadline[QUEUE_DEPTH];
    logic [7:0]  slot_ident[QUEUE_DEPTH];
    logic [31:0] slot_period[QUEUE_DEPTH];
    logic        slot_rearm[QUEUE_DEPTH];
    int          queued;

    // pacing state of both sides
    int          req_wait   = 0;
    int          send_burst = 0;
    int          stall_left = 0;
    int          recv_burst = 0;

    // run statistics
    int          req_taken     = 0;
    int          adds_taken    = 0;
    int          adds_refused  = 0;
    int          fires_seen    = 0;
    int          results_seen  = 0;
    int          mismatch_cnt  = 0;

    sorted_timer_event_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (drv_req.op),
        .i_duration  (drv_req.dur),
        .i_event_id  (drv_req.ident),
        .i_periodic  (drv_req.rearm),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_kind      (o_kind),
        .o_fired_id  (o_fired_id),
        .o_fire_time (o_fire_time),
        .o_last      (o_last)
    );

    // clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // queue model
    // ------------------------------------------------------------------

    // insert behind every entry with a deadline at or before the new one
    function automatic void slot_insert(logic [63:0] dl, logic [7:0] id,
                                        logic [31:0] per, logic rep);
        int pos;
        pos = 0;
        while (pos < queued && slot_deadline[pos] <= dl)
            pos++;
        for (int i = queued; i > pos; i--) begin
            slot_deadline[i] = slot_deadline[i-1];
            slot_ident[i]    = slot_ident[i-1];
            slot_period[i]   = slot_period[i-1];
            slot_rearm[i]    = slot_rearm[i-1];
        end
        slot_deadline[pos] = dl;
        slot_ident[pos]    = id;
        slot_period[pos]   = per;
        slot_rearm[pos]    = rep;
        queued++;
    endfunction

    function automatic void slot_pop();
        for (int i = 0; i + 1 < queued; i++) begin
            slot_deadline[i] = slot_deadline[i+1];
            slot_ident[i]    = slot_ident[i+1];
            slot_period[i]   = slot_period[i+1];
            slot_rearm[i]    = slot_rearm[i+1];
        end
        queued--;
    endfunction

    // work out the results of one accepted request and queue them
    function automatic void apply_timer_item(t_req rq);
        t_fire_rec   rec;
        t_fire_rec   tick_recs[$];
        logic [7:0]  hid;
        logic [31:0] hper;
        logic        hrep;
        if (rq.op == OP_ADD) begin
            rec.ident = rq.ident;
            rec.stamp = now_ticks;
            rec.last  = 1'b1;
            if (queued >= QUEUE_DEPTH) begin
                rec.kind = KIND_ADD_FULL;
                adds_refused++;
            end else begin
                slot_insert(now_ticks + {32'd0, rq.dur}, rq.ident, rq.dur, rq.rearm);
                rec.kind = KIND_ADD_OK;
                adds_taken++;
            end
            awaited_results.push_back(rec);
        end else begin
            now_ticks = now_ticks + 64'd1;
            // fire from the head, bounded per tick
            while (tick_recs.size() < MAX_FIRES && queued > 0 &&
                   slot_deadline[0] <= now_ticks) begin
                hid  = slot_ident[0];
                hper = slot_period[0];
                hrep = slot_rearm[0];
                slot_pop();
                if (hrep)
                    slot_insert(now_ticks + {32'd0, hper}, hid, hper, hrep);
                rec.kind  = KIND_FIRED;
                rec.ident = hid;
                rec.stamp = now_ticks;
                rec.last  = 1'b0;
                tick_recs.push_back(rec);
            end
            fires_seen += tick_recs.size();
            foreach (tick_recs[i]) begin
                rec      = tick_recs[i];
                rec.last = (i == tick_recs.size() - 1);
                awaited_results.push_back(rec);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // idle cycles before the next request or result, with gap-free bursts
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void queue_req(logic op, logic [31:0] dur, logic [7:0] id, logic rep);
        t_req rq;
        rq.op    = op;
        rq.dur   = dur;
        rq.ident = id;
        rq.rearm = rep;
        req_backlog.push_back(rq);
    endfunction

    // mostly short timeouts so events keep draining
    function automatic logic [31:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel == 0)
            return $urandom;
        if (sel < 12)
            return $urandom_range(13, 60);
        return $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int add_pct;
        int lasting;
        logic [31:0] dur;
        lasting = 0;

        // longest timeout with all-ones id, then a zero timeout with id zero
        queue_req(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        queue_req(OP_ADD, 32'd0, 8'h00, 1'b0);
        queue_req(OP_TICK, 32'd0, 8'h00, 1'b0);
        // quiet tick
        queue_req(OP_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // fill the queue with equal deadlines plus one periodic event
        for (int i = 0; i < 14; i++)
            queue_req(OP_ADD, 32'd2, 8'h10 + i[7:0], 1'b0);
        queue_req(OP_ADD, 32'd3, 8'hA5, 1'b1);
        // add to a full queue
        queue_req(OP_ADD, 32'd1, 8'h5A, 1'b0);
        // quiet, then all ties fire in arrival order, then the periodic one
        repeat (3) queue_req(OP_TICK, 32'd0, 8'h00, 1'b0);

        // random phases with differing add density
        for (int blk = 0; blk < 7; blk++) begin
            case ($urandom_range(0, 2))
                0: add_pct = 30;
                1: add_pct = 50;
                default: add_pct = 75;
            endcase
            for (int n = 0; n < 40; n++) begin
                if ($urandom_range(0, 99) < add_pct) begin
                    // rare periodic or never-due events stay forever, so cap them
                    if (lasting < 8 && $urandom_range(0, 99) < 3) begin
                        queue_req(OP_ADD, $urandom_range(2, 40), 8'($urandom), 1'b1);
                        lasting++;
                    end else begin
                        dur = pick_duration();
                        if (dur > 32'd60) begin
                            if (lasting < 8)
                                lasting++;
                            else
                                dur = {28'd0, dur[3:0]};
                        end
                        queue_req(OP_ADD, dur, 8'($urandom), 1'b0);
                    end
                end else begin
                    queue_req(OP_TICK, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end

        // drain one-shot events, then a periodic event with zero period,
        // which is due again at once and hits the per-tick fire bound
        repeat (64) queue_req(OP_TICK, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
        queue_req(OP_ADD, 32'd0, 8'h3C, 1'b1);
        repeat (3) queue_req(OP_TICK, 32'd0, 8'h00, 1'b0);
        stim_ready = 1'b1;
    end

    // ------------------------------------------------------------------
    // driver: one request at a time from the backlog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic open_slot;
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            req_wait  <= 0;
            now_ticks  = '0;
            queued     = 0;
        end else begin
            open_slot = !in_valid || o_in_ready;
            if (in_valid && o_in_ready) begin
                apply_timer_item(drv_req);
                req_taken++;
            end
            if (open_slot) begin
                if (req_wait > 0) begin
                    req_wait <= req_wait - 1;
                    in_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    drv_req  <= req_backlog.pop_front();
                    in_valid <= 1'b1;
                    req_wait <= draw_gap(send_burst);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: take results with random stalls, check against the model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fire_rec want;
        int        nxt;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing pending, id", o_fired_id, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch("kind", o_kind, want.kind);
                    if (o_fired_id !== want.ident)
                        report_mismatch("fired_id", o_fired_id, want.ident);
                    if (o_fire_time !== want.stamp)
                        report_mismatch("fire_time", o_fire_time, want.stamp);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
                nxt = draw_gap(recv_burst);
                stall_left <= nxt;
                out_ready  <= (nxt == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------
    initial begin
        wait (i_rst_n && stim_ready);
        while (req_backlog.size() > 0 || in_valid || awaited_results.size() > 0)
            @(posedge i_clk);
        // a tick fires at most MAX_FIRES events, each possibly rearmed
        repeat (4 * MAX_FIRES + 20) @(posedge i_clk);
        $display("covered %0d requests: %0d adds queued, %0d adds refused, %0d timer fires",
                 req_taken, adds_taken, adds_refused, fires_seen);
        $display("checked %0d results, %0d mismatches", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout with %0d results still pending", awaited_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/stq_chain.sv
rtl/sorted_timer_event_queue.sv
verif/tb_top.sv
